### design/sit_pkg.sv
`timescale 1ns / 1ps
// Package for the segment intersection test: widths and item types.
package sit_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int DET_BITS   = PROD_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
    } seg_in_t;

    typedef struct packed {
        logic intersects;
        logic parallel;
    } seg_out_t;

endpackage

### design/segment_intersection_test.sv
`timescale 1ns / 1ps
// Segment intersection test: four-stage pipeline, top level.
//
// Takes two segments A and B as signed end points and reports whether they
// meet, exactly. With r the direction of A, s that of B and q the start of B
// relative to the start of A, d = cross(r, s), t = cross(q, s) / d and
// u = cross(q, r) / d; the segments meet when d is non-zero and both t and u
// lie in [0, 1], compared as numerators against d with its sign folded in.
// A zero d is reported as parallel and never as a hit, overlapping collinear
// and degenerate segments included. The stages are the end point differences,
// six signed multipliers, the subtractions forming d and both numerators, and
// the range compares into the output register; one item is taken every cycle
// while m_ready keeps up. Ready travels back through the four stage valids, so
// bubbles close up and an item is accepted while a result waits on m_ready.
module segment_intersection_test
    import sit_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  seg_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output seg_out_t m_data
);

    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: coordinates relative to the start of A, and the reversed direction of B
    logic signed [DIFF_BITS-1:0] ax_s, ay_s, ax_e, ay_e, bx_s, by_s, bx_e, by_e;
    logic signed [DIFF_BITS-1:0] x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;
    logic signed [DIFF_BITS-1:0] sx_reg, sy_reg;

    // stage 2: products
    logic signed [PROD_BITS-1:0] p_d0_reg, p_d1_reg, p_t0_reg, p_t1_reg;
    logic signed [PROD_BITS-1:0] p_u0_reg, p_u1_reg;

    // stage 3: determinant and numerators
    logic signed [DET_BITS-1:0] det_reg, tnum_reg, unum_reg;

    // stage 4: result
    seg_out_t res_next, res_reg;
    logic     t_pos, u_pos, t_neg, u_neg;

    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v4_reg;
    assign m_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    assign ax_s = DIFF_BITS'(s_data.a_start_x);
    assign ay_s = DIFF_BITS'(s_data.a_start_y);
    assign ax_e = DIFF_BITS'(s_data.a_end_x);
    assign ay_e = DIFF_BITS'(s_data.a_end_y);
    assign bx_s = DIFF_BITS'(s_data.b_start_x);
    assign by_s = DIFF_BITS'(s_data.b_start_y);
    assign bx_e = DIFF_BITS'(s_data.b_end_x);
    assign by_e = DIFF_BITS'(s_data.b_end_y);

    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            x2_reg <= ax_e - ax_s;
            y2_reg <= ay_e - ay_s;
            x3_reg <= bx_s - ax_s;
            y3_reg <= by_s - ay_s;
            x4_reg <= bx_e - ax_s;
            y4_reg <= by_e - ay_s;
            sx_reg <= bx_s - bx_e;
            sy_reg <= by_s - by_e;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            p_d0_reg <= y2_reg * sx_reg;
            p_d1_reg <= x2_reg * sy_reg;
            p_t0_reg <= x3_reg * y4_reg;
            p_t1_reg <= y3_reg * x4_reg;
            p_u0_reg <= x3_reg * y2_reg;
            p_u1_reg <= y3_reg * x2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            det_reg  <= DET_BITS'(p_d0_reg) - DET_BITS'(p_d1_reg);
            tnum_reg <= DET_BITS'(p_t0_reg) - DET_BITS'(p_t1_reg);
            unum_reg <= DET_BITS'(p_u0_reg) - DET_BITS'(p_u1_reg);
        end
    end

    always_comb begin
        t_pos = (tnum_reg >= 0) && (tnum_reg <= det_reg);
        u_pos = (unum_reg >= 0) && (unum_reg <= det_reg);
        t_neg = (tnum_reg <= 0) && (tnum_reg >= det_reg);
        u_neg = (unum_reg <= 0) && (unum_reg >= det_reg);
        res_next.parallel   = (det_reg == '0);
        res_next.intersects = 1'b0;
        if (det_reg > 0) begin
            res_next.intersects = t_pos && u_pos;
        end else if (det_reg < 0) begin
            res_next.intersects = t_neg && u_neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            res_reg <= res_next;
        end
    end

endmodule

### design/sit_checker.sv
`timescale 1ns / 1ps
// Port checker for the segment intersection test, bound to the top level.
module sit_checker
    import sit_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input seg_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input seg_out_t m_data
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.intersects && m_data.parallel))
        else $error("parallel item reported as a hit");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output stage");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
